@@ hdl/tlbb_pkg.sv @@
// tlbb_pkg: field widths, move kinds, fixed-point angle constants and the
// transfer payload types of the toolpath length / time / bounding box block.
// No dependencies.
`timescale 1ns / 1ps

package tlbb_pkg;

  localparam int COORD_W = 24;
  localparam int SUM_W   = 48;
  localparam int MOVE_W  = 28;
  localparam int FEED_W  = 17;
  localparam int DWELL_W = 22;
  localparam int KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_RAPID  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINEAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLUNGE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CW     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CCW    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  localparam logic [0:0] REG_RAPID_FEED = 1'b0;
  localparam logic [FEED_W-1:0] RAPID_FEED_RST = 17'd5000;

  // angles: radians with 30 fraction bits
  localparam logic [32:0] PI_Q      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q = 33'd1686629713;
  localparam logic [32:0] TWO_PI_Q  = 33'd6746518852;
  localparam logic [MOVE_W-1:0] MOVE_MAX = 28'hFFFFFFF;
  localparam logic [29:0] TIME_SCALE  = 30'd60000;
  localparam logic [29:0] DWELL_SCALE = 30'd1000;

  localparam logic [31:0] ATAN_TAB [30] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef struct packed {
    logic [KIND_W-1:0]         seg_kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [FEED_W-1:0]         feed_rate;
    logic [DWELL_W-1:0]        dwell_ms;
  } seg_item_t;

  typedef struct packed {
    logic [MOVE_W-1:0]         move_length;
    logic [SUM_W-1:0]          path_length;
    logic [SUM_W-1:0]          path_time;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } res_item_t;

endpackage

@@ hdl/toolpath_length_time_bbox.sv @@
// toolpath_length_time_bbox: per-move length, running length, running time
// and bounding box of a machine toolpath. Depends on tlbb_pkg.
//
// channel  dir  handshake             payload
// seg      in   seg_valid/seg_stall   tlbb_pkg::seg_item_t, one move
// res      out  res_valid/res_stall   tlbb_pkg::res_item_t, one per move
// apb      in   psel/penable/pwrite   rapid feed register at byte address 0
//
// one move at a time; the work of a move, straight or arc, is set by the shared
// one-bit-per-cycle multiply-accumulate unit, the 32-step square root, the
// 30-step angle loop and the 44-step divider. clear and unknown kinds go from
// decode straight to the done step. rst is synchronous and empties the path.
// a result waits in the output register while res_stall is high; a new move is
// taken meanwhile and holds in its last step until the register frees.
`timescale 1ns / 1ps

module toolpath_length_time_bbox (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  tlbb_pkg::seg_item_t   seg,
  output logic                  res_valid,
  input  logic                  res_stall,
  output tlbb_pkg::res_item_t   res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tlbb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CHORD, S_CHORD_SQ, S_RAD, S_RAD_SQ, S_CROSS, S_NORM,
    S_SMAG, S_SMAG_SQ, S_CORDIC, S_ANGLE, S_ARC, S_TIME_SEL, S_TIME, S_DIV,
    S_DWELL, S_DONE
  } state_t;

  state_t state;

  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] sp [3];
  logic signed [COORD_W-1:0] ep [3];
  logic signed [COORD_W-1:0] cp [3];
  logic [FEED_W-1:0]         feed_in;
  logic [DWELL_W-1:0]        dwell;
  logic [FEED_W-1:0]         rapid_feed;

  logic [SUM_W-1:0]          length_sum;
  logic [SUM_W-1:0]          time_sum;
  logic signed [COORD_W-1:0] low_corner [3];
  logic signed [COORD_W-1:0] high_corner [3];
  logic                      has_points;

  // multiply-accumulate unit
  logic signed [63:0] acc;
  logic [63:0]        mcand;
  logic [29:0]        mplier;
  logic               mac_neg;
  logic               mac_run;
  logic [1:0]         term;
  logic [1:0]         qsel;

  // square root unit
  logic [63:0] sq_n;
  logic [63:0] sq_r;
  logic [63:0] sq_bit;
  logic        sq_run;

  logic [COORD_W:0]   radius;
  logic [50:0]        mg [4];
  logic               dot_neg;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [34:0] cz;
  logic [4:0]         cd_i;
  logic [32:0]        ang;

  logic [43:0]       div_num;
  logic [FEED_W-1:0] div_rem;
  logic [5:0]        div_cnt;
  logic              div_run;

  logic [MOVE_W-1:0] move;

  // ---------------------------------------------------------------- datapath
  logic signed [COORD_W:0] dch [3];
  logic signed [COORD_W:0] av [3];
  logic signed [COORD_W:0] bv [3];
  logic [FEED_W-1:0]       feed_sel;
  logic                    arc_kind;
  logic                    arc_ok;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dch[i] = (COORD_W+1)'(sp[i]) - (COORD_W+1)'(ep[i]);
      av[i]  = (COORD_W+1)'(sp[i]) - (COORD_W+1)'(cp[i]);
      bv[i]  = (COORD_W+1)'(ep[i]) - (COORD_W+1)'(cp[i]);
    end
    feed_sel = (kind == KIND_RAPID) ? rapid_feed : feed_in;
    arc_kind = kind inside {KIND_CW, KIND_CCW};
    arc_ok   = arc_kind &&
               (sp[0] != cp[0] || sp[1] != cp[1] || sp[2] != cp[2]) &&
               (ep[0] != cp[0] || ep[1] != cp[1] || ep[2] != cp[2]);
  end

  // operands of the current product term
  logic signed [33:0] opx;
  logic signed [30:0] opy;
  logic               op_sub;
  logic               op_last;

  always_comb begin
    opx     = '0;
    opy     = '0;
    op_sub  = 1'b0;
    op_last = 1'b1;
    case (state)
      S_CHORD: begin
        op_last = (term == 2'd2);
        case (term)
          2'd0: begin opx = 34'(dch[0]); opy = 31'(dch[0]); end
          2'd1: begin opx = 34'(dch[1]); opy = 31'(dch[1]); end
          default: begin opx = 34'(dch[2]); opy = 31'(dch[2]); end
        endcase
      end
      S_RAD: begin
        op_last = (term == 2'd2);
        case (term)
          2'd0: begin opx = 34'(av[0]); opy = 31'(av[0]); end
          2'd1: begin opx = 34'(av[1]); opy = 31'(av[1]); end
          default: begin opx = 34'(av[2]); opy = 31'(av[2]); end
        endcase
      end
      S_CROSS: begin
        case ({qsel, term})
          4'b0000: begin opx = 34'(av[1]); opy = 31'(bv[2]); op_last = 1'b0; end
          4'b0001: begin opx = 34'(av[2]); opy = 31'(bv[1]); op_sub = 1'b1; end
          4'b0100: begin opx = 34'(av[2]); opy = 31'(bv[0]); op_last = 1'b0; end
          4'b0101: begin opx = 34'(av[0]); opy = 31'(bv[2]); op_sub = 1'b1; end
          4'b1000: begin opx = 34'(av[0]); opy = 31'(bv[1]); op_last = 1'b0; end
          4'b1001: begin opx = 34'(av[1]); opy = 31'(bv[0]); op_sub = 1'b1; end
          4'b1100: begin opx = 34'(av[0]); opy = 31'(bv[0]); op_last = 1'b0; end
          4'b1101: begin opx = 34'(av[1]); opy = 31'(bv[1]); op_last = 1'b0; end
          default: begin opx = 34'(av[2]); opy = 31'(bv[2]); end
        endcase
      end
      S_SMAG: begin
        op_last = (term == 2'd2);
        case (term)
          2'd0: begin opx = 34'(mg[0][29:0]); opy = 31'(mg[0][29:0]); end
          2'd1: begin opx = 34'(mg[1][29:0]); opy = 31'(mg[1][29:0]); end
          default: begin opx = 34'(mg[2][29:0]); opy = 31'(mg[2][29:0]); end
        endcase
      end
      S_ARC: begin
        opx = 34'(ang);
        opy = 31'(radius);
      end
      S_TIME: begin
        opx = 34'(move);
        opy = 31'(TIME_SCALE);
      end
      S_DWELL: begin
        opx = 34'(dwell);
        opy = 31'(DWELL_SCALE);
      end
      default: ;
    endcase
  end

  logic [33:0]        opx_mag;
  logic [30:0]        opy_mag;
  logic signed [63:0] acc_step;
  logic [63:0]        acc_mag;

  always_comb begin
    opx_mag  = opx[33] ? 34'(-opx) : 34'(opx);
    opy_mag  = opy[30] ? 31'(-opy) : 31'(opy);
    acc_step = mac_neg ? acc - mcand : acc + mcand;
    acc_mag  = acc[63] ? 64'(-acc) : 64'(acc);
  end

  logic [63:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = sq_r + sq_bit;
  assign sq_ge  = sq_n >= sq_sum;

  logic signed [33:0] cxs;
  logic signed [33:0] cys;
  logic signed [34:0] atan_q;
  logic [32:0]        z_cl;

  always_comb begin
    cxs    = cx >>> cd_i;
    cys    = cy >>> cd_i;
    atan_q = 35'(ATAN_TAB[cd_i]);
    if (cz[34]) begin
      z_cl = '0;
    end else if (cz > 35'(PI_Q)) begin
      z_cl = PI_Q;
    end else begin
      z_cl = cz[32:0];
    end
  end

  logic [MOVE_W-1:0] arc_move;
  assign arc_move = (acc[63:30] > 34'(MOVE_MAX)) ? MOVE_MAX : acc[30+MOVE_W-1:30];

  logic [FEED_W:0] div_sh;
  logic            div_ge;
  logic [43:0]     div_num_next;
  logic [FEED_W-1:0] div_rem_next;

  always_comb begin
    div_sh = {div_rem, div_num[43]};
    div_ge = div_sh >= {1'b0, feed_sel};
    div_num_next = {div_num[42:0], div_ge};
    div_rem_next = div_ge ? FEED_W'(div_sh - {1'b0, feed_sel}) : div_sh[FEED_W-1:0];
  end

  // totals and box after the current move
  function automatic logic signed [COORD_W-1:0] smin(
      input logic signed [COORD_W-1:0] p, input logic signed [COORD_W-1:0] q);
    return (p < q) ? p : q;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(
      input logic signed [COORD_W-1:0] p, input logic signed [COORD_W-1:0] q);
    return (p > q) ? p : q;
  endfunction

  logic [SUM_W:0]            len_add;
  logic [SUM_W:0]            tim_add;
  logic [SUM_W-1:0]          len_next;
  logic [SUM_W-1:0]          time_next;
  logic signed [COORD_W-1:0] lo_next [3];
  logic signed [COORD_W-1:0] hi_next [3];
  logic                      has_next;

  always_comb begin
    len_add   = {1'b0, length_sum} + (SUM_W+1)'(move);
    tim_add   = {1'b0, time_sum} + (SUM_W+1)'(acc[SUM_W-1:0]);
    len_next  = length_sum;
    time_next = time_sum;
    lo_next   = low_corner;
    hi_next   = high_corner;
    has_next  = has_points;
    if (kind == KIND_CLEAR) begin
      len_next  = '0;
      time_next = '0;
      has_next  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_next[i] = '0;
        hi_next[i] = '0;
      end
    end else if (kind inside {[KIND_RAPID:KIND_CCW]}) begin
      len_next  = len_add[SUM_W] ? '1 : len_add[SUM_W-1:0];
      time_next = tim_add[SUM_W] ? '1 : tim_add[SUM_W-1:0];
      has_next  = 1'b1;
      for (int i = 0; i < 3; i++) begin
        lo_next[i] = has_points ? smin(low_corner[i], sp[i]) : sp[i];
        hi_next[i] = has_points ? smax(high_corner[i], sp[i]) : sp[i];
        lo_next[i] = smin(lo_next[i], ep[i]);
        hi_next[i] = smax(hi_next[i], ep[i]);
        if (arc_kind) begin
          lo_next[i] = smin(lo_next[i], cp[i]);
          hi_next[i] = smax(hi_next[i], cp[i]);
        end
      end
    end
  end

  assign seg_stall = (state != S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2:2] == REG_RAPID_FEED) ? 32'(rapid_feed) : '0;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      mac_run     <= 1'b0;
      sq_run      <= 1'b0;
      div_run     <= 1'b0;
      term        <= '0;
      qsel        <= '0;
      rapid_feed  <= RAPID_FEED_RST;
      length_sum  <= '0;
      time_sum    <= '0;
      has_points  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        low_corner[i]  <= '0;
        high_corner[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr[2:2] == REG_RAPID_FEED) begin
        rapid_feed <= pwdata[FEED_W-1:0];
      end
      // the done step reloads the output register itself
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (seg_valid) begin
            kind    <= seg.seg_kind;
            sp[0]   <= seg.start_x;
            sp[1]   <= seg.start_y;
            sp[2]   <= seg.start_z;
            ep[0]   <= seg.end_x;
            ep[1]   <= seg.end_y;
            ep[2]   <= seg.end_z;
            cp[0]   <= seg.center_x;
            cp[1]   <= seg.center_y;
            cp[2]   <= seg.center_z;
            feed_in <= seg.feed_rate;
            dwell   <= seg.dwell_ms;
            state   <= S_DECODE;
          end
        end

        S_DECODE: begin
          move <= '0;
          acc  <= '0;
          term <= '0;
          if (kind inside {[KIND_RAPID:KIND_CCW]}) begin
            state <= S_CHORD;
          end else begin
            state <= S_DONE;
          end
        end

        S_CHORD, S_RAD, S_CROSS, S_SMAG, S_ARC, S_TIME, S_DWELL: begin
          if (!mac_run) begin
            mcand   <= 64'(opx_mag);
            mplier  <= opy_mag[29:0];
            mac_neg <= opx[33] ^ opy[30] ^ op_sub;
            mac_run <= 1'b1;
          end else if (mplier != '0) begin
            if (mplier[0]) begin
              acc <= acc_step;
            end
            mcand  <= {mcand[62:0], 1'b0};
            mplier <= {1'b0, mplier[29:1]};
          end else begin
            mac_run <= 1'b0;
            if (!op_last) begin
              term <= term + 2'd1;
            end else begin
              term <= '0;
              case (state)
                S_CHORD: state <= S_CHORD_SQ;
                S_RAD:   state <= S_RAD_SQ;
                S_CROSS: begin
                  acc <= '0;
                  case (qsel)
                    2'd0: mg[0] <= acc_mag[50:0];
                    2'd1: mg[1] <= acc_mag[50:0];
                    2'd2: mg[2] <= acc_mag[50:0];
                    default: begin
                      mg[3]   <= acc_mag[50:0];
                      dot_neg <= acc[63];
                    end
                  endcase
                  if (qsel == 2'd3) begin
                    state <= S_NORM;
                  end
                  qsel <= qsel + 2'd1;
                end
                S_SMAG: state <= S_SMAG_SQ;
                S_ARC: begin
                  move  <= arc_move;
                  state <= S_TIME_SEL;
                end
                S_TIME: begin
                  div_num <= acc[43:0];
                  div_rem <= '0;
                  div_cnt <= '0;
                  state   <= S_DIV;
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end

        S_CHORD_SQ, S_RAD_SQ, S_SMAG_SQ: begin
          if (!sq_run) begin
            sq_n   <= acc;
            sq_r   <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            sq_run <= 1'b1;
          end else if (sq_bit != '0) begin
            if (sq_ge) begin
              sq_n <= sq_n - sq_sum;
              sq_r <= {1'b0, sq_r[63:1]} + sq_bit;
            end else begin
              sq_r <= {1'b0, sq_r[63:1]};
            end
            sq_bit <= {2'b00, sq_bit[63:2]};
          end else begin
            sq_run <= 1'b0;
            acc    <= '0;
            case (state)
              S_CHORD_SQ: begin
                move  <= MOVE_W'(sq_r);
                state <= arc_ok ? S_RAD : S_TIME_SEL;
              end
              S_RAD_SQ: begin
                radius <= sq_r[COORD_W:0];
                qsel   <= '0;
                state  <= S_CROSS;
              end
              default: begin
                // vector angle from (dot, |cross|), rotated by a quarter turn
                // when the dot product is negative
                cd_i <= '0;
                if (dot_neg) begin
                  cz <= 35'(HALF_PI_Q);
                  cx <= 34'(sq_r[30:0]);
                  cy <= 34'(mg[3][29:0]);
                end else begin
                  cz <= '0;
                  cx <= 34'(mg[3][29:0]);
                  cy <= 34'(sq_r[30:0]);
                end
                state <= S_CORDIC;
              end
            endcase
          end
        end

        S_NORM: begin
          if (mg[0][50:30] != '0 || mg[1][50:30] != '0 ||
              mg[2][50:30] != '0 || mg[3][50:30] != '0) begin
            for (int i = 0; i < 4; i++) begin
              mg[i] <= {1'b0, mg[i][50:1]};
            end
          end else begin
            acc   <= '0;
            term  <= '0;
            state <= S_SMAG;
          end
        end

        S_CORDIC: begin
          if (!cy[33]) begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + atan_q;
          end else begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - atan_q;
          end
          if (cd_i == 5'd29) begin
            state <= S_ANGLE;
          end else begin
            cd_i <= cd_i + 5'd1;
          end
        end

        S_ANGLE: begin
          ang   <= (kind == KIND_CW) ? TWO_PI_Q - z_cl : z_cl;
          acc   <= '0;
          term  <= '0;
          state <= S_ARC;
        end

        S_TIME_SEL: begin
          acc   <= '0;
          term  <= '0;
          state <= (feed_sel != '0) ? S_TIME : S_DWELL;
        end

        S_DIV: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd43) begin
            acc   <= 64'(div_num_next);
            term  <= '0;
            state <= S_DWELL;
          end
        end

        S_DONE: begin
          if (!res_valid || !res_stall) begin
            length_sum  <= len_next;
            time_sum    <= time_next;
            low_corner  <= lo_next;
            high_corner <= hi_next;
            has_points  <= has_next;
            res.move_length <= move;
            res.path_length <= len_next;
            res.path_time   <= time_next;
            res.box_min_x   <= has_next ? lo_next[0] : '0;
            res.box_min_y   <= has_next ? lo_next[1] : '0;
            res.box_min_z   <= has_next ? lo_next[2] : '0;
            res.box_max_x   <= has_next ? hi_next[0] : '0;
            res.box_max_y   <= has_next ? hi_next[1] : '0;
            res.box_max_z   <= has_next ? hi_next[2] : '0;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_move_at_a_time: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> seg_stall)
    else $error("second transfer taken while a move is in work");

  a_length_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && kind != KIND_CLEAR |-> len_next >= length_sum)
    else $error("path length dropped without a clear");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) && kind == KIND_CLEAR |->
      res.path_length == '0 && res.path_time == '0 && res.move_length == '0)
    else $error("clear did not report an empty path");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.box_min_x <= res.box_max_x && res.box_min_y <= res.box_max_y &&
                  res.box_min_z <= res.box_max_z)
    else $error("bounding box corners out of order");
`endif

endmodule
